/* rtl/sqr_pkg.sv */
package sqr_pkg;

    // field widths fixed by the interface
    localparam int BIN_W   = 10;
    localparam int POWER_W = 32;
    localparam int RATIO_W = 17;
    localparam int WLEN_W  = 7;
    localparam int RANK_W  = 6;

    // ratio format: unsigned fraction with 16 fraction bits
    localparam int RATIO_FRAC_BITS = 16;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

    // register reset values
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 7'd50;
    localparam logic [RANK_W-1:0] LOW_RANK_RESET      = 6'd5;
    localparam logic [RANK_W-1:0] HIGH_RANK_RESET     = 6'd28;

    // register indexes (word address)
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] REG_LOW_RANK      = 2'd1;
    localparam logic [1:0] REG_HIGH_RANK     = 2'd2;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic [POWER_W-1:0] power_value;
    } sqr_in_t;

    typedef struct packed {
        logic [BIN_W-1:0]   out_bin;
        logic [POWER_W-1:0] low_quantile;
        logic [POWER_W-1:0] high_quantile;
        logic [RATIO_W-1:0] quantile_ratio;
    } sqr_out_t;

    // sorter row control
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } sqr_sort_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_READ,
        ST_DRAIN,
        ST_SELECT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } sqr_state_t;

endpackage

/* rtl/sqr_sorter.sv */
module sqr_sorter
    import sqr_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sqr_sort_ctrl_t     ctrl,
    input  logic [POWER_W-1:0] din,
    output logic [POWER_W-1:0] head
);

    logic [POWER_W-1:0]    cell_reg  [MAX_WINDOW];
    logic [POWER_W-1:0]    cell_next [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] vld_reg;
    logic [MAX_WINDOW-1:0] vld_next;
    logic [MAX_WINDOW-1:0] gt;

    // empty cells count as larger than any value
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            gt[i] = !vld_reg[i] || (cell_reg[i] > din);
        end
    end

    // insertion keeps the row sorted ascending, shift moves it toward the head
    always_comb
    begin
        cell_next = cell_reg;
        vld_next  = vld_reg;
        if (ctrl.clear)
        begin
            vld_next = '0;
        end
        else if (ctrl.load)
        begin
            if (gt[0])
            begin
                cell_next[0] = din;
            end
            vld_next[0] = 1'b1;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                if (gt[i])
                begin
                    cell_next[i] = gt[i-1] ? cell_reg[i-1] : din;
                end
                vld_next[i] = vld_reg[i] | vld_reg[i-1];
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < MAX_WINDOW - 1; i++)
            begin
                cell_next[i] = cell_reg[i+1];
                vld_next[i]  = vld_reg[i+1];
            end
            vld_next[MAX_WINDOW-1] = 1'b0;
        end
    end

    // occupancy bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // cell values
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign head = cell_reg[0];

endmodule

/* rtl/sqr_divider.sv */
module sqr_divider
    import sqr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [POWER_W-1:0] dividend,
    input  logic [POWER_W-1:0] divisor,
    output logic               done,
    output logic [RATIO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(RATIO_FRAC_BITS);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [POWER_W-1:0] rem_reg;
    logic [POWER_W-1:0] divisor_reg;
    logic [RATIO_W-1:0] quot_reg;

    logic [POWER_W:0]   trial;
    logic [POWER_W:0]   diff;
    logic               ge;

    // one restoring step: remainder stays below the divisor
    always_comb
    begin
        trial = {rem_reg, 1'b0};
        diff  = trial - {1'b0, divisor_reg};
        ge    = trial >= {1'b0, divisor_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (divisor == '0 || dividend >= divisor)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RATIO_FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: zero divisor gives 0, ratio of one or more saturates
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= dividend;
            divisor_reg <= divisor;
            if (divisor == '0)
            begin
                quot_reg <= '0;
            end
            else if (dividend >= divisor)
            begin
                quot_reg <= RATIO_ONE;
            end
            else
            begin
                quot_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[POWER_W-1:0] : trial[POWER_W-1:0];
            quot_reg <= {quot_reg[RATIO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* rtl/sliding_quantile_ratio.sv */
// Sliding-window quantile ratio per frequency bin.
// Requests arrive on the sample channel (sample_valid / sample_stall / sample_data),
// each a PSD value tagged with its bin. Results leave on the result channel
// (result_valid / result_stall / result_data): the bin, the order statistics at
// low_rank and high_rank of the bin's window, and low/high with 65536 = 1.0.
// A bin gives no result until its window holds window_length values (limited to
// 2..MAX_WINDOW); a bin index of NUM_BINS or more is dropped.
// Per request: a non-producing one goes through accept and window update. A
// producing one adds L reads of the bin's window from the window memory into
// an insertion sorter row (one per cycle, set by the single read port), up to
// L shifts to pick both ranks, a divider start, then the serial divider.
// One request is in work at a time; a new request is taken while a finished
// result waits in the output register, and result_stall holds that register.
// After reset the per-bin fill/slot memory is cleared, one bin a cycle, before
// sample_stall drops. Registers reset to 50, 5 and 28;
// the APB port takes writes at any time.
module sliding_quantile_ratio
    import sqr_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int NUM_BINS   = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sqr_in_t     sample_data,
    output logic        result_valid,
    input  logic        result_stall,
    output sqr_out_t    result_data
);

    localparam int BW = $clog2(NUM_BINS);
    localparam int SW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int WA = BW + SW;
    localparam int MW = CW + SW;

    // configuration registers
    logic [WLEN_W-1:0] window_length_reg;
    logic [RANK_W-1:0] low_rank_reg;
    logic [RANK_W-1:0] high_rank_reg;
    logic              cfg_we;

    // memories
    logic [POWER_W-1:0] win_mem  [0:(NUM_BINS << SW) - 1];
    logic [MW-1:0]      meta_mem [0:NUM_BINS-1];
    logic [POWER_W-1:0] win_q;
    logic [MW-1:0]      meta_q;

    // control
    sqr_state_t     state_reg;
    sqr_state_t     state_next;
    sqr_sort_ctrl_t sort_ctrl;
    logic           accept;
    logic           in_range;
    logic           meta_rd_en;
    logic           meta_we;
    logic           win_we;
    logic           win_rd_en;
    logic           div_start;
    logic           div_done;
    logic           out_load;
    logic           clr_last;
    logic           rd_last;
    logic           sel_last;

    logic [BW-1:0]  clr_addr_reg;
    logic [SW-1:0]  rd_idx_reg;
    logic [SW-1:0]  sel_cnt_reg;
    logic           ld_pend_reg;

    // request payload
    logic [BIN_W-1:0]   bin_reg;
    logic [POWER_W-1:0] val_reg;
    logic [BW-1:0]      bin_addr;

    // window bookkeeping
    logic [31:0]   wl_ext;
    logic [CW-1:0] len;
    logic [CW-1:0] fill_raw;
    logic [SW-1:0] slot_raw;
    logic [CW-1:0] fill_c;
    logic [SW-1:0] slot_c;
    logic [CW-1:0] slot_inc;
    logic          filling;
    logic [SW-1:0] wslot;
    logic [SW-1:0] nslot;
    logic [CW-1:0] nfill;
    logic          produce;
    logic [SW-1:0] klo;
    logic [SW-1:0] khi;
    logic [SW-1:0] kmax;

    logic [MW-1:0] meta_waddr_data;
    logic [BW-1:0] meta_waddr;

    // results
    logic [POWER_W-1:0] head;
    logic [POWER_W-1:0] qlo_reg;
    logic [POWER_W-1:0] qhi_reg;
    logic [RATIO_W-1:0] div_quot;
    logic               out_valid_reg;
    sqr_out_t           out_data_reg;

    // apb register file
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RESET;
            low_rank_reg      <= LOW_RANK_RESET;
            high_rank_reg     <= HIGH_RANK_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[WLEN_W-1:0];
                REG_LOW_RANK:      low_rank_reg      <= pwdata[RANK_W-1:0];
                REG_HIGH_RANK:     high_rank_reg     <= pwdata[RANK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW_LENGTH: prdata = 32'(window_length_reg);
            REG_LOW_RANK:      prdata = 32'(low_rank_reg);
            REG_HIGH_RANK:     prdata = 32'(high_rank_reg);
            default:           prdata = '0;
        endcase
    end

    // effective length and ranks
    always_comb
    begin
        wl_ext = 32'(window_length_reg);
        if (wl_ext < 32'd2)
        begin
            len = CW'(2);
        end
        else if (wl_ext > 32'(MAX_WINDOW))
        begin
            len = CW'(MAX_WINDOW);
        end
        else
        begin
            len = CW'(wl_ext);
        end
        klo  = (32'(low_rank_reg) >= 32'(len)) ? SW'(len - CW'(1)) : SW'(low_rank_reg);
        khi  = (32'(high_rank_reg) >= 32'(len)) ? SW'(len - CW'(1)) : SW'(high_rank_reg);
        kmax = (klo > khi) ? klo : khi;
    end

    // per-bin fill and slot update
    always_comb
    begin
        fill_raw = meta_q[MW-1:SW];
        slot_raw = meta_q[SW-1:0];
        fill_c   = (fill_raw > len) ? len : fill_raw;
        slot_c   = (CW'(slot_raw) >= len) ? '0 : slot_raw;
        filling  = fill_c < len;
        slot_inc = CW'(slot_c) + CW'(1);
        if (filling)
        begin
            wslot   = SW'(fill_c);
            nslot   = '0;
            nfill   = fill_c + CW'(1);
            produce = (fill_c + CW'(1)) == len;
        end
        else
        begin
            wslot   = slot_c;
            nslot   = (slot_inc >= len) ? '0 : SW'(slot_inc);
            nfill   = fill_c;
            produce = 1'b1;
        end
    end

    assign bin_addr = BW'(bin_reg);
    assign in_range = 32'(sample_data.bin_index) < 32'(NUM_BINS);
    assign clr_last = clr_addr_reg == BW'(NUM_BINS - 1);
    assign rd_last  = CW'(rd_idx_reg) == (len - CW'(1));
    assign sel_last = sel_cnt_reg == kmax;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sample_valid && in_range)
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                state_next = produce ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (sel_last)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        sample_stall    = 1'b1;
        accept          = 1'b0;
        meta_rd_en      = 1'b0;
        meta_we         = 1'b0;
        win_we          = 1'b0;
        win_rd_en       = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        sort_ctrl.clear = 1'b0;
        sort_ctrl.load  = ld_pend_reg;
        sort_ctrl.shift = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                meta_we = 1'b1;
            end
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                accept       = sample_valid;
                meta_rd_en   = sample_valid && in_range;
            end
            ST_META:
            begin
                meta_we         = 1'b1;
                win_we          = 1'b1;
                sort_ctrl.clear = 1'b1;
            end
            ST_READ:
            begin
                win_rd_en = 1'b1;
            end
            ST_SELECT:
            begin
                sort_ctrl.shift = 1'b1;
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_idx_reg   <= '0;
            sel_cnt_reg  <= '0;
            ld_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ld_pend_reg <= win_rd_en;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + BW'(1);
            end
            if (state_reg == ST_META)
            begin
                rd_idx_reg  <= '0;
                sel_cnt_reg <= '0;
            end
            if (win_rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + SW'(1);
            end
            if (sort_ctrl.shift)
            begin
                sel_cnt_reg <= sel_cnt_reg + SW'(1);
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bin_reg <= sample_data.bin_index;
            val_reg <= sample_data.power_value;
        end
    end

    // fill/slot memory: clearing pass after reset, then read-modify-write
    assign meta_waddr      = (state_reg == ST_CLEAR) ? clr_addr_reg : bin_addr;
    assign meta_waddr_data = (state_reg == ST_CLEAR) ? '0 : {nfill, nslot};

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_waddr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_rd_en)
        begin
            meta_q <= meta_mem[BW'(sample_data.bin_index)];
        end
    end

    // window memory
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[WA'({bin_addr, wslot})] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_rd_en)
        begin
            win_q <= win_mem[WA'({bin_addr, rd_idx_reg})];
        end
    end

    // sorter row
    sqr_sorter #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sort_ctrl),
        .din   (win_q),
        .head  (head)
    );

    // pick both ranks as the sorted row shifts past the head
    always_ff @(posedge clk)
    begin
        if (sort_ctrl.shift)
        begin
            if (sel_cnt_reg == klo)
            begin
                qlo_reg <= head;
            end
            if (sel_cnt_reg == khi)
            begin
                qhi_reg <= head;
            end
        end
    end

    // ratio
    sqr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (qlo_reg),
        .divisor  (qhi_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.out_bin        <= bin_reg;
            out_data_reg.low_quantile   <= qlo_reg;
            out_data_reg.high_quantile  <= qhi_reg;
            out_data_reg.quantile_ratio <= div_quot;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

/* tb/sv/tb.sv */
module tb;
    import sqr_pkg::*;

    localparam int MAX_WIN       = 64;
    localparam int BINS          = 1024;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_AT       = 330;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_CYCLES  = 16;
    localparam int SETTLE_CYCLES = 200;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sqr_in_t     sample_data  = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    sqr_out_t    result_data;

    // pending requests and the results they are predicted to give
    sqr_in_t  pending_samples [$];
    sqr_out_t expected_ratios [$];

    // mirror of the per-bin windows and of the registers
    logic [POWER_W-1:0] win_vals [BINS][MAX_WIN];
    int unsigned        win_fill [BINS];
    int unsigned        win_next [BINS];
    logic [WLEN_W-1:0]  cfg_wlen = WINDOW_LENGTH_RESET;
    logic [RANK_W-1:0]  cfg_lo   = LOW_RANK_RESET;
    logic [RANK_W-1:0]  cfg_hi   = HIGH_RANK_RESET;

    int error_count    = 0;
    int cycle_count    = 0;
    int accepted_count = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    bit hold_done      = 1'b0;
    bit idle_on        = 1'b1;

    sliding_quantile_ratio #(
        .MAX_WINDOW(MAX_WIN),
        .NUM_BINS  (BINS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_data (sample_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

    always #10 clk = ~clk;

    task automatic log_error(string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // k-th smallest of the first len entries of a bin's window
    function automatic logic [POWER_W-1:0] window_rank(int b, int unsigned len, int unsigned k);
        bit [POWER_W-1:0] vals [$];
        for (int i = 0; i < len; i++)
            vals.push_back(win_vals[b][i]);
        vals.sort();
        return vals[k];
    endfunction

    // update the bin's window and queue the result once it is full
    function automatic void predict_window(sqr_in_t req);
        int                 b;
        int unsigned        len;
        int unsigned        fill;
        int unsigned        slot;
        int unsigned        klo;
        int unsigned        khi;
        logic [POWER_W-1:0] qlo;
        logic [POWER_W-1:0] qhi;
        logic [47:0]        quot;
        sqr_out_t           res;
        b = int'(req.bin_index);
        if (b >= BINS)
            return;
        len = cfg_wlen;
        if (len < 2)
            len = 2;
        if (len > MAX_WIN)
            len = MAX_WIN;
        fill = win_fill[b];
        slot = win_next[b];
        if (fill > len)
            fill = len;
        if (slot >= len)
            slot = 0;
        if (fill < len)
        begin
            win_vals[b][fill] = req.power_value;
            fill++;
            win_fill[b] = fill;
            win_next[b] = 0;
            if (fill < len)
                return;
        end
        else
        begin
            win_vals[b][slot] = req.power_value;
            slot = (slot + 1 >= len) ? 0 : slot + 1;
            win_fill[b] = fill;
            win_next[b] = slot;
        end
        klo = (cfg_lo >= len) ? len - 1 : cfg_lo;
        khi = (cfg_hi >= len) ? len - 1 : cfg_hi;
        qlo = window_rank(b, len, klo);
        qhi = window_rank(b, len, khi);
        res.out_bin       = req.bin_index;
        res.low_quantile  = qlo;
        res.high_quantile = qhi;
        if (qhi == '0)
            res.quantile_ratio = '0;
        else
        begin
            quot = (48'(qlo) << RATIO_FRAC_BITS) / 48'(qhi);
            res.quantile_ratio = (quot > RATIO_ONE) ? RATIO_ONE : quot[RATIO_W-1:0];
        end
        expected_ratios.push_back(res);
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(int unsigned wlen, int unsigned lo, int unsigned hi);
        apb_write(REG_WINDOW_LENGTH, 32'(wlen));
        apb_write(REG_LOW_RANK, 32'(lo));
        apb_write(REG_HIGH_RANK, 32'(hi));
        cfg_wlen = WLEN_W'(wlen);
        cfg_lo   = RANK_W'(lo);
        cfg_hi   = RANK_W'(hi);
        @(negedge clk);
    endtask

    task automatic queue_sample(int unsigned b, logic [POWER_W-1:0] v);
        sqr_in_t s;
        s.bin_index   = BIN_W'(b);
        s.power_value = v;
        pending_samples.push_back(s);
    endtask

    // mostly a few hot bins, sometimes any bin; small values give ties and zeros
    task automatic queue_random(int count, int lo_bin, int hi_bin);
        sqr_in_t s;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                s.bin_index = BIN_W'($urandom_range(0, BINS - 1));
            else
                s.bin_index = BIN_W'($urandom_range(lo_bin, hi_bin));
            case ($urandom_range(0, 7))
                0, 1:    s.power_value = POWER_W'($urandom_range(0, 3));
                2:       s.power_value = $urandom_range(0, 1) ? '1 : '0;
                3:       s.power_value = $urandom();
                default: s.power_value = $urandom() >> $urandom_range(0, 31);
            endcase
            pending_samples.push_back(s);
        end
    endtask

    // block is idle once every request is in and every result is out
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_valid || expected_ratios.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            send_gap     <= 0;
        end
        else if (!(sample_valid && sample_stall))
        begin
            if (send_gap != 0)
            begin
                sample_valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (pending_samples.size() == 0)
                sample_valid <= 1'b0;
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                sample_valid <= 1'b0;
                send_gap     <= $urandom_range(0, 6);
            end
            else
            begin
                sample_valid <= 1'b1;
                sample_data  <= pending_samples.pop_front();
            end
        end
    end

    // result stall: random bursts plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
            hold_done    <= 1'b0;
        end
        else if (!hold_done && accepted_count >= HOLD_AT)
        begin
            result_stall <= 1'b1;
            stall_left   <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 6);
        end
        else
            result_stall <= 1'b0;
    end

    // monitor: check results, predict from accepted requests
    always @(posedge clk)
    begin
        sqr_out_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_ratios.size() == 0)
                    log_error($sformatf("result for bin %0d with none expected",
                                        result_data.out_bin));
                else
                begin
                    want = expected_ratios.pop_front();
                    if (result_data.out_bin !== want.out_bin)
                        log_error($sformatf("out_bin %0d, expected %0d",
                                            result_data.out_bin, want.out_bin));
                    if (result_data.low_quantile !== want.low_quantile)
                        log_error($sformatf("bin %0d low_quantile %h, expected %h", want.out_bin,
                                            result_data.low_quantile, want.low_quantile));
                    if (result_data.high_quantile !== want.high_quantile)
                        log_error($sformatf("bin %0d high_quantile %h, expected %h", want.out_bin,
                                            result_data.high_quantile, want.high_quantile));
                    if (result_data.quantile_ratio !== want.quantile_ratio)
                        log_error($sformatf("bin %0d quantile_ratio %h, expected %h", want.out_bin,
                                            result_data.quantile_ratio, want.quantile_ratio));
                end
            end
            if (sample_valid && !sample_stall)
            begin
                predict_window(sample_data);
                accepted_count <= accepted_count + 1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // length below the minimum: zero divisor, full-scale values, all-ones bin
        set_window(0, 0, 1);
        queue_sample(0, 32'h0);
        queue_sample(0, 32'h0);
        queue_sample(0, 32'h5);
        queue_sample(1023, 32'hFFFF_FFFF);
        queue_sample(1023, 32'hFFFF_FFFF);
        queue_sample(1023, 32'h1);
        queue_sample(512, 32'h3);
        queue_sample(512, 32'h7);
        wait_idle();

        // ranks past the window: low above high saturates the ratio
        set_window(1, 63, 0);
        queue_sample(1, 32'd10);
        queue_sample(1, 32'd4);
        queue_sample(1, 32'd4);
        queue_sample(1, 32'h8000_0000);
        wait_idle();

        // ties in a three-deep window
        set_window(3, 1, 1);
        queue_sample(2, 32'd7);
        queue_sample(2, 32'd7);
        queue_sample(2, 32'd2);
        queue_sample(2, 32'd7);
        queue_sample(2, 32'd2);
        wait_idle();

        // long windows, growing windows that were filled short
        set_window(50, 5, 28);
        queue_random(130, 0, 1);
        wait_idle();
        set_window(127, 63, 0);
        queue_random(200, 2, 3);
        wait_idle();
        set_window(64, 0, 63);
        queue_random(150, 0, 3);
        wait_idle();

        // short random windows: shrink and regrow on shared bins
        for (int p = 0; p < 8; p++)
        begin
            int unsigned wl;
            int unsigned lo;
            int unsigned hi;
            case ($urandom_range(0, 9))
                0:       wl = $urandom_range(0, 127);
                1:       wl = $urandom_range(0, 1);
                default: wl = $urandom_range(2, 10);
            endcase
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
            idle_on = (p != 2 && p != 7);
            set_window(wl, lo, hi);
            queue_random(110, 0, 7);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_ratios.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_ratios.size()));
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sliding_quantile_ratio.f */
rtl/sqr_pkg.sv
rtl/sqr_sorter.sv
rtl/sqr_divider.sv
rtl/sliding_quantile_ratio.sv
tb/sv/tb.sv
